### hw/rtl/owbm_pkg.sv
// Package for the 1-Wire bit-level bus master core.
// Holds shared types, opcode and register-index codes, and reset defaults.
// No dependencies.
package owbm_pkg;

   // Configuration register file
   localparam int unsigned CFG_W      = 10;
   localparam int unsigned NUM_REGS   = 8;
   localparam int unsigned REG_IDX_W  = 3;
   localparam int unsigned APB_DATA_W = 32;
   localparam int unsigned APB_ADDR_W = 5;

   // Timer and read recovery defaults
   localparam int unsigned TIMER_WIDTH_DEF       = 10;
   localparam int unsigned READ_RECOVER_TIME_DEF = 55;

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Opcodes
   localparam logic [1:0] OP_RESET = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PRESENCE_SMPL  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RESET_RECOVER  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WR1_RELEASE    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_WR0_LOW        = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_WR0_RELEASE    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_READ_SMPL      = 3'd7;

   // Register reset values
   localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
   localparam logic [CFG_W-1:0] RST_PRESENCE_SMPL = 10'd70;
   localparam logic [CFG_W-1:0] RST_RESET_RECOVER = 10'd410;
   localparam logic [CFG_W-1:0] RST_SHORT_LOW     = 10'd6;
   localparam logic [CFG_W-1:0] RST_WR1_RELEASE   = 10'd64;
   localparam logic [CFG_W-1:0] RST_WR0_LOW       = 10'd60;
   localparam logic [CFG_W-1:0] RST_WR0_RELEASE   = 10'd10;
   localparam logic [CFG_W-1:0] RST_READ_SMPL     = 10'd9;

   // Bus slot phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LOW    = 3'd1,
      PH_SPACE  = 3'd2,
      PH_SAMPLE = 3'd3,
      PH_TAIL   = 3'd4
   } phase_type;

   // Classified tick from the front
   typedef struct packed {
      logic       start;
      logic [1:0] opcode;
      logic       write_bit;
      logic       line_level;
   } tick_type;

   // Timing registers as seen by the engine
   typedef struct packed {
      logic [CFG_W-1:0] reset_low_time;
      logic [CFG_W-1:0] presence_sample_time;
      logic [CFG_W-1:0] reset_recover_time;
      logic [CFG_W-1:0] short_low_time;
      logic [CFG_W-1:0] write_one_release_time;
      logic [CFG_W-1:0] write_zero_low_time;
      logic [CFG_W-1:0] write_zero_release_time;
      logic [CFG_W-1:0] read_sample_time;
   } cfg_type;

endpackage

### hw/rtl/owbm_csr.sv
// Configuration register file with an APB-style slave port.
// Depends on owbm_pkg.
module owbm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [owbm_pkg::APB_ADDR_W-1:0]   paddr,
   input  logic [owbm_pkg::APB_DATA_W-1:0]   pwdata,
   output logic [owbm_pkg::APB_DATA_W-1:0]   prdata,
   output logic                              pready,
   output owbm_pkg::cfg_type                 cfg
);
   import owbm_pkg::*;

   logic [CFG_W-1:0]     regs_ff [NUM_REGS];
   logic [REG_IDX_W-1:0] idx;
   logic                 wr_en;

   assign idx    = paddr[APB_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register writes, defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_RESET_LOW]     <= RST_RESET_LOW;
         regs_ff[REG_PRESENCE_SMPL] <= RST_PRESENCE_SMPL;
         regs_ff[REG_RESET_RECOVER] <= RST_RESET_RECOVER;
         regs_ff[REG_SHORT_LOW]     <= RST_SHORT_LOW;
         regs_ff[REG_WR1_RELEASE]   <= RST_WR1_RELEASE;
         regs_ff[REG_WR0_LOW]       <= RST_WR0_LOW;
         regs_ff[REG_WR0_RELEASE]   <= RST_WR0_RELEASE;
         regs_ff[REG_READ_SMPL]     <= RST_READ_SMPL;
      end else if (wr_en) begin
         regs_ff[idx] <= pwdata[CFG_W-1:0];
      end
   end

   // Read back
   assign prdata = {{(APB_DATA_W-CFG_W){1'b0}}, regs_ff[idx]};

   // Named view for the engine
   assign cfg.reset_low_time          = regs_ff[REG_RESET_LOW];
   assign cfg.presence_sample_time    = regs_ff[REG_PRESENCE_SMPL];
   assign cfg.reset_recover_time      = regs_ff[REG_RESET_RECOVER];
   assign cfg.short_low_time          = regs_ff[REG_SHORT_LOW];
   assign cfg.write_one_release_time  = regs_ff[REG_WR1_RELEASE];
   assign cfg.write_zero_low_time     = regs_ff[REG_WR0_LOW];
   assign cfg.write_zero_release_time = regs_ff[REG_WR0_RELEASE];
   assign cfg.read_sample_time        = regs_ff[REG_READ_SMPL];

endmodule

### hw/rtl/owbm_front.sv
// Front end: accepts tick transactions, classifies the command, and queues them.
// Depends on owbm_pkg.
module owbm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command_valid,
   input  logic [1:0]         req_opcode,
   input  logic               req_write_bit,
   input  logic               req_line_level,
   output logic               q_valid,
   output owbm_pkg::tick_type q_tick,
   input  logic               q_pop
);
   import owbm_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   tick_type         queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   tick_type         cls;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) return '0;
      else return p + PTR_W'(1);
   endfunction

   // Classify: only a defined opcode can start a command
   always_comb begin
      cls.start      = req_command_valid &&
                       (req_opcode == OP_RESET || req_opcode == OP_WRITE ||
                        req_opcode == OP_READ);
      cls.opcode     = req_opcode;
      cls.write_bit  = req_write_bit;
      cls.line_level = req_line_level;
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_tick    = queue_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push  ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### hw/rtl/owbm_engine.sv
// Back end: bus slot sequencer with tick timer and registered result stage.
// Depends on owbm_pkg.
module owbm_engine #(
   parameter int unsigned TIMER_WIDTH       = owbm_pkg::TIMER_WIDTH_DEF,
   parameter int unsigned READ_RECOVER_TIME = owbm_pkg::READ_RECOVER_TIME_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  owbm_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  owbm_pkg::tick_type q_tick,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_drive_low,
   output logic               rsp_busy_res,
   output logic               rsp_done_res,
   output logic               rsp_result_bit
);
   import owbm_pkg::*;

   localparam int unsigned TW     = TIMER_WIDTH;
   localparam int unsigned TMAX   = (1 << TW) - 1;
   localparam int unsigned CMP_W  = ((TW > CFG_W) ? TW : CFG_W) + 1;
   localparam int unsigned RR_CL  = (READ_RECOVER_TIME == 0) ? 1 :
                                    ((READ_RECOVER_TIME > TMAX) ? TMAX : READ_RECOVER_TIME);
   localparam logic [TW-1:0] TMAX_V = '1;
   localparam logic [TW-1:0] RR_LEN = TW'(RR_CL);

   phase_type     phase_ff, phase_in, ph_cur;
   logic [TW-1:0] tick_ff, tick_in, tc_cur;
   logic [1:0]    op_ff, op_cur;
   logic          bit_ff, bit_cur;
   logic          cap_ff, cap_cur, cap_in;
   logic          start;
   logic [TW-1:0] low_len, space_len, tail_len;
   logic          drive, busy, done;
   logic          fire;

   // Zero length counts as one tick, long lengths saturate to the timer
   function automatic logic [TW-1:0] clamp_len(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      if (v == '0) return TW'(1);
      else if (wide > CMP_W'(TMAX)) return TMAX_V;
      else return TW'(v);
   endfunction

   assign fire  = q_valid && (!rsp_valid || !rsp_stall);
   assign q_pop = fire;

   // Command launch from idle on the same tick
   always_comb begin
      start   = (phase_ff == PH_IDLE) && q_tick.start;
      op_cur  = start ? q_tick.opcode : op_ff;
      bit_cur = start ? ((q_tick.opcode == OP_WRITE) && q_tick.write_bit) : bit_ff;
      cap_cur = start ? 1'b0 : cap_ff;
   end

   // Phase lengths for the active command
   always_comb begin
      if (op_cur == OP_RESET) low_len = clamp_len(cfg.reset_low_time);
      else if (op_cur == OP_WRITE && !bit_cur) low_len = clamp_len(cfg.write_zero_low_time);
      else low_len = clamp_len(cfg.short_low_time);

      space_len = clamp_len((op_cur == OP_RESET) ? cfg.presence_sample_time
                                                 : cfg.read_sample_time);

      if (op_cur == OP_WRITE)
         tail_len = clamp_len(bit_cur ? cfg.write_one_release_time
                                      : cfg.write_zero_release_time);
      else if (op_cur == OP_RESET)
         tail_len = clamp_len(cfg.reset_recover_time);
      else
         tail_len = RR_LEN;

      ph_cur = start ? PH_LOW : phase_ff;
      tc_cur = start ? (low_len - TW'(1)) : tick_ff;
   end

   // Next state
   always_comb begin
      phase_in = ph_cur;
      tick_in  = tc_cur;
      cap_in   = cap_cur;
      case (ph_cur)
         PH_LOW: begin
            if (tc_cur == '0) begin
               if (op_cur == OP_WRITE) begin
                  phase_in = PH_TAIL;
                  tick_in  = tail_len - TW'(1);
               end else begin
                  phase_in = PH_SPACE;
                  tick_in  = space_len - TW'(1);
               end
            end else begin
               tick_in = tc_cur - TW'(1);
            end
         end
         PH_SPACE: begin
            if (tc_cur == '0) phase_in = PH_SAMPLE;
            else tick_in = tc_cur - TW'(1);
         end
         PH_SAMPLE: begin
            // Presence is active low; read samples the level as is
            cap_in = (op_cur == OP_RESET) ? !q_tick.line_level : q_tick.line_level;
            if (tail_len == TW'(1)) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_TAIL;
               tick_in  = tail_len - TW'(2);
            end
         end
         PH_TAIL: begin
            if (tc_cur == '0) phase_in = PH_IDLE;
            else tick_in = tc_cur - TW'(1);
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Outputs for this tick
   always_comb begin
      drive = 1'b0;
      busy  = 1'b0;
      done  = 1'b0;
      case (ph_cur)
         PH_LOW: begin
            drive = 1'b1;
            busy  = 1'b1;
         end
         PH_SPACE: begin
            busy = 1'b1;
         end
         PH_SAMPLE: begin
            busy = 1'b1;
            done = (tail_len == TW'(1));
         end
         PH_TAIL: begin
            busy = 1'b1;
            done = (tc_cur == '0);
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         op_ff    <= '0;
         bit_ff   <= 1'b0;
         cap_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         op_ff    <= op_cur;
         bit_ff   <= bit_cur;
         cap_ff   <= cap_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (fire) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_drive_low  <= drive;
         rsp_busy_res   <= busy;
         rsp_done_res   <= done;
         rsp_result_bit <= done && cap_in;
      end
   end

endmodule

### hw/rtl/one_wire_bit_master_core.sv
// Top level of the 1-Wire bit-level bus master.
// Depends on owbm_pkg, owbm_csr, owbm_front and owbm_engine.
//
//   Channel  Direction  Handshake            Carries
//   req_     in         req_valid/req_stall  one tick: command, opcode, write bit, line level
//   rsp_     out        rsp_valid/rsp_stall  one tick: drive, busy, done, result bit
//   APB      in/out     psel/penable/pready  eight 10-bit timing registers
//
// One tick transaction per unstalled clock cycle sustained; a result is presented once
// its tick has passed the queue slot (written at the accepting edge) and the result register.
// The sequencer handles one tick per unstalled cycle; the two-entry queue absorbs rsp_stall.
// Reset is synchronous: sequencer idle, queue empty, registers back to defaults.
// req_stall rises only when the queue is full; a stalled result holds steady.
module one_wire_bit_master_core #(
   parameter int unsigned TIMER_WIDTH       = owbm_pkg::TIMER_WIDTH_DEF,
   parameter int unsigned READ_RECOVER_TIME = owbm_pkg::READ_RECOVER_TIME_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Tick input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command_valid,
   input  logic [1:0]                       req_opcode,
   input  logic                             req_write_bit,
   input  logic                             req_line_level,
   // Tick result
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_drive_low,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic                             rsp_result_bit,
   // Configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [owbm_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [owbm_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [owbm_pkg::APB_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import owbm_pkg::*;

   cfg_type  cfg;
   logic     q_valid;
   tick_type q_tick;
   logic     q_pop;

   owbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   owbm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command_valid (req_command_valid),
      .req_opcode        (req_opcode),
      .req_write_bit     (req_write_bit),
      .req_line_level    (req_line_level),
      .q_valid           (q_valid),
      .q_tick            (q_tick),
      .q_pop             (q_pop)
   );

   owbm_engine #(
      .TIMER_WIDTH       (TIMER_WIDTH),
      .READ_RECOVER_TIME (READ_RECOVER_TIME)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_tick         (q_tick),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_low  (rsp_drive_low),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_result_bit (rsp_result_bit)
   );

endmodule

### verif/one_wire_bit_master_checker.sv
`timescale 1ns / 100ps
// Checker for the 1-Wire bit master: mirrors the timing registers from the APB port,
// forecasts drive/busy/done/result per accepted tick and compares every result.
// Depends on owbm_pkg.
module one_wire_bit_master_checker #(
   parameter int unsigned TIMER_WIDTH       = owbm_pkg::TIMER_WIDTH_DEF,
   parameter int unsigned READ_RECOVER_TIME = owbm_pkg::READ_RECOVER_TIME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command_valid,
   input  logic [1:0]                      req_opcode,
   input  logic                            req_write_bit,
   input  logic                            req_line_level,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_drive_low,
   input  logic                            rsp_busy_res,
   input  logic                            rsp_done_res,
   input  logic                            rsp_result_bit,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [owbm_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [owbm_pkg::APB_DATA_W-1:0] pwdata,
   input  logic                            pready,
   input  logic                            wrap_up,
   output int unsigned                     fail_count
);
   import owbm_pkg::*;

   localparam int unsigned TMAX = (1 << TIMER_WIDTH) - 1;

   // One tick of line activity as the master reports it
   typedef struct packed {
      logic drive_low;
      logic busy;
      logic done;
      logic result_bit;
   } line_tick_type;

   // Mirrored timing registers
   logic [CFG_W-1:0] timing_reg [NUM_REGS];

   // Bus slot sequencer state
   phase_type    slot_phase;
   int unsigned  slot_count;
   logic [1:0]   slot_op;
   logic         slot_bit;
   logic         slot_capture;

   line_tick_type slot_forecast [$];
   line_tick_type forecast_in;
   line_tick_type want;
   line_tick_type got;
   logic          wrapped = 1'b0;

   initial fail_count = 0;

   // zero lengths count as one tick, long ones saturate at the timer limit
   function automatic int unsigned fit_len(input int unsigned ticks);
      if (ticks == 0) return 1;
      if (ticks > TMAX) return TMAX;
      return ticks;
   endfunction

   function automatic int unsigned low_len();
      if (slot_op == OP_RESET) return fit_len(timing_reg[REG_RESET_LOW]);
      if (slot_op == OP_WRITE && !slot_bit) return fit_len(timing_reg[REG_WR0_LOW]);
      return fit_len(timing_reg[REG_SHORT_LOW]);
   endfunction

   function automatic int unsigned space_len();
      if (slot_op == OP_RESET) return fit_len(timing_reg[REG_PRESENCE_SMPL]);
      return fit_len(timing_reg[REG_READ_SMPL]);
   endfunction

   function automatic int unsigned tail_len();
      if (slot_op == OP_WRITE)
         return fit_len(slot_bit ? timing_reg[REG_WR1_RELEASE] : timing_reg[REG_WR0_RELEASE]);
      if (slot_op == OP_RESET) return fit_len(timing_reg[REG_RESET_RECOVER]);
      return fit_len(READ_RECOVER_TIME);
   endfunction

   task automatic enter_phase(input phase_type next_phase, input int unsigned len);
      slot_phase = next_phase;
      slot_count = (len - 1) & TMAX;
   endtask

   // Advance the slot sequencer by one tick and forecast its outputs
   task automatic step_bus_slot(input logic cv, input logic [1:0] op, input logic wb,
                                input logic lvl, output line_tick_type o);
      int unsigned tail;
      o = '0;
      if (slot_phase > PH_TAIL) slot_phase = PH_IDLE;

      // idle master starts a command on the tick it is offered
      if (slot_phase == PH_IDLE && cv && op <= OP_READ) begin
         slot_op      = op;
         slot_bit     = (op == OP_WRITE) ? wb : 1'b0;
         slot_capture = 1'b0;
         enter_phase(PH_LOW, low_len());
      end

      case (slot_phase)
         PH_LOW: begin
            o.drive_low = 1'b1;
            o.busy      = 1'b1;
            if (slot_count == 0) begin
               if (slot_op == OP_WRITE) enter_phase(PH_TAIL, tail_len());
               else enter_phase(PH_SPACE, space_len());
            end else begin
               slot_count--;
            end
         end
         PH_SPACE: begin
            o.busy = 1'b1;
            if (slot_count == 0) slot_phase = PH_SAMPLE;
            else slot_count--;
         end
         PH_SAMPLE: begin
            // sample tick is also the first recovery tick; low line means presence
            o.busy       = 1'b1;
            slot_capture = (slot_op == OP_RESET) ? ~lvl : lvl;
            tail         = tail_len();
            if (tail == 1) begin
               o.done     = 1'b1;
               slot_phase = PH_IDLE;
            end else begin
               enter_phase(PH_TAIL, tail - 1);
            end
         end
         PH_TAIL: begin
            o.busy = 1'b1;
            if (slot_count == 0) begin
               o.done     = 1'b1;
               slot_phase = PH_IDLE;
            end else begin
               slot_count--;
            end
         end
         default: ;
      endcase

      if (o.done) o.result_bit = slot_capture;
   endtask

   task automatic compare_bit(input string field, input logic exp_bit, input logic act_bit);
      if (act_bit !== exp_bit) begin
         $error("%s: expected %0b, actual %0b", field, exp_bit, act_bit);
         fail_count++;
      end
   endtask

   // Watch config writes, tick transactions and result transactions
   always @(posedge clock) begin
      if (reset) begin
         timing_reg[REG_RESET_LOW]     = RST_RESET_LOW;
         timing_reg[REG_PRESENCE_SMPL] = RST_PRESENCE_SMPL;
         timing_reg[REG_RESET_RECOVER] = RST_RESET_RECOVER;
         timing_reg[REG_SHORT_LOW]     = RST_SHORT_LOW;
         timing_reg[REG_WR1_RELEASE]   = RST_WR1_RELEASE;
         timing_reg[REG_WR0_LOW]       = RST_WR0_LOW;
         timing_reg[REG_WR0_RELEASE]   = RST_WR0_RELEASE;
         timing_reg[REG_READ_SMPL]     = RST_READ_SMPL;
         slot_phase   = PH_IDLE;
         slot_count   = 0;
         slot_op      = OP_RESET;
         slot_bit     = 1'b0;
         slot_capture = 1'b0;
         slot_forecast.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            timing_reg[paddr[APB_ADDR_W-1:2]] = pwdata[CFG_W-1:0];

         if (req_valid && !req_stall) begin
            step_bus_slot(req_command_valid, req_opcode, req_write_bit, req_line_level,
                          forecast_in);
            slot_forecast.push_back(forecast_in);
         end

         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_drive_low, rsp_busy_res, rsp_done_res, rsp_result_bit};
            if (slot_forecast.size() == 0) begin
               $error("result transaction with no tick waiting");
               fail_count++;
            end else begin
               want = slot_forecast.pop_front();
               compare_bit("drive_low", want.drive_low, got.drive_low);
               compare_bit("busy_res", want.busy, got.busy);
               compare_bit("done_res", want.done, got.done);
               compare_bit("result_bit", want.result_bit, got.result_bit);
            end
         end

         if (wrap_up && !wrapped) begin
            wrapped = 1'b1;
            if (slot_forecast.size() != 0) begin
               $error("%0d results never arrived", slot_forecast.size());
               fail_count += slot_forecast.size();
            end
         end
      end
   end

endmodule

### verif/one_wire_bit_master_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for one_wire_bit_master_core: drives ticks, APB timing writes and
// result back-pressure; one_wire_bit_master_checker does all prediction and checks.
// Depends on owbm_pkg, one_wire_bit_master_core and one_wire_bit_master_checker.
module one_wire_bit_master_core_tb;
   import owbm_pkg::*;

   // opcode with no meaning, must leave the master idle
   localparam logic [1:0] OP_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid         = 1'b0;
   logic       req_command_valid = 1'b0;
   logic [1:0] req_opcode        = OP_RESET;
   logic       req_write_bit     = 1'b0;
   logic       req_line_level    = 1'b1;
   logic       rsp_stall         = 1'b0;
   logic       psel              = 1'b0;
   logic       penable           = 1'b0;
   logic       pwrite            = 1'b0;
   logic [APB_ADDR_W-1:0] paddr  = '0;
   logic [APB_DATA_W-1:0] pwdata = '0;
   logic       wrap_up           = 1'b0;
   logic       no_gaps           = 1'b0;

   logic req_stall, rsp_valid, rsp_drive_low, rsp_busy_res, rsp_done_res, rsp_result_bit;
   logic pready;
   logic [APB_DATA_W-1:0] prdata;
   int unsigned fail_count;

   int unsigned ticks_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned idle_results = 0;
   int unsigned done_results = 0;
   logic [APB_DATA_W-1:0] timing_plan [NUM_REGS];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   one_wire_bit_master_core dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_command_valid, .req_opcode, .req_write_bit,
      .req_line_level,
      .rsp_valid, .rsp_stall, .rsp_drive_low, .rsp_busy_res, .rsp_done_res,
      .rsp_result_bit,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   one_wire_bit_master_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall, .req_command_valid, .req_opcode, .req_write_bit,
      .req_line_level,
      .rsp_valid, .rsp_stall, .rsp_drive_low, .rsp_busy_res, .rsp_done_res,
      .rsp_result_bit,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .wrap_up, .fail_count
   );

   // Result side back-pressure
   always @(posedge clock)
      rsp_stall <= !no_gaps && ($urandom_range(99) < 29);

   // Count result transactions so stimulus can tell when the master is quiet
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (!rsp_busy_res) idle_results <= idle_results + 1;
         if (rsp_done_res) done_results <= done_results + 1;
      end
   end

   // Offer one tick and hold it until accepted
   task automatic send_tick(input logic cv, input logic [1:0] op, input logic wb,
                            input logic lvl);
      while (!no_gaps && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command_valid <= cv;
      req_opcode        <= op;
      req_write_bit     <= wb;
      req_line_level    <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // One full command at a constant line level, with a stray command on its
   // second tick that the busy master must drop
   task automatic run_command(input logic [1:0] op, input logic wb, input logic lvl);
      int unsigned mark;
      logic [1:0]  stray_op;
      mark     = done_results;
      stray_op = 2'($urandom_range(3));
      send_tick(1'b1, op, wb, lvl);
      send_tick(1'b1, stray_op, ~wb, lvl);
      while (done_results == mark) send_tick(1'b0, stray_op, wb, lvl);
   endtask

   // Every command kind under the current timing; reset slots only when asked,
   // since they run to nearly a thousand ticks at the default timing
   task automatic directed_set(input logic with_reset);
      if (with_reset) begin
         run_command(OP_RESET, 1'b0, 1'b0);   // device pulls low: presence
         run_command(OP_RESET, 1'b1, 1'b1);   // empty bus
      end
      run_command(OP_WRITE, 1'b1, 1'b1);
      run_command(OP_WRITE, 1'b0, 1'b0);
      run_command(OP_READ, 1'b0, 1'b0);
      run_command(OP_READ, 1'b1, 1'b1);
      send_tick(1'b1, OP_NONE, 1'b1, 1'b0);
   endtask

   // Idle ticks until the master reports not busy, then drain all results
   task automatic quiesce();
      int unsigned mark;
      req_valid <= 1'b0;
      while (results_seen != ticks_sent) @(posedge clock);
      mark = idle_results;
      while (idle_results == mark) send_tick(1'b0, OP_RESET, 1'b0, 1'b1);
      req_valid <= 1'b0;
      while (results_seen != ticks_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB writes of every timing register: setup then access
   task automatic apply_timing_plan();
      for (int i = 0; i < int'(NUM_REGS); i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= APB_ADDR_W'(4 * i);
         pwdata  <= timing_plan[i];
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         psel    <= 1'b0;
         penable <= 1'b0;
         pwrite  <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stimulus
   initial begin
      int unsigned pass_no;
      logic [1:0]  op;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset-value timing, write and read slots
      directed_set(1'b0);

      // every length at one tick
      foreach (timing_plan[i]) timing_plan[i] = 1;
      quiesce();
      apply_timing_plan();
      directed_set(1'b1);

      // zero lengths, junk in the unused upper data bits
      foreach (timing_plan[i]) timing_plan[i] = $urandom & ~32'h3FF;
      quiesce();
      apply_timing_plan();
      directed_set(1'b1);

      // random traffic under short random timing
      for (pass_no = 0; pass_no < 6; pass_no++) begin
         foreach (timing_plan[i])
            timing_plan[i] = (pass_no == 5) ? $urandom_range(40) : $urandom_range(12);
         quiesce();
         apply_timing_plan();
         no_gaps <= (pass_no == 3);
         repeat (115) begin
            op = ($urandom_range(99) < 8) ? OP_NONE : 2'($urandom_range(2));
            send_tick($urandom_range(99) < 25, op, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
         end
      end

      req_valid <= 1'b0;
      while (results_seen != ticks_sent) @(posedge clock);
      repeat (8) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #8000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_csr.sv
hw/rtl/owbm_front.sv
hw/rtl/owbm_engine.sv
hw/rtl/one_wire_bit_master_core.sv
verif/one_wire_bit_master_checker.sv
verif/one_wire_bit_master_core_tb.sv
